// File: sv/bsd_pkg.sv
`timescale 1ns / 1ps

package bsd_pkg;

  // number of axes of the point and the box
  localparam int AXES = 3;

  // radicand bits taken by each square-root cell (one root bit per cell)
  localparam int RAD_STEP = 2;

endpackage

// File: sv/bsd_ifs.sv
`timescale 1ns / 1ps

interface bsd_in_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;
  logic        [COORD_BITS-2:0] half_x;
  logic        [COORD_BITS-2:0] half_y;
  logic        [COORD_BITS-2:0] half_z;

  modport source (
    output valid, pos_x, pos_y, pos_z, half_x, half_y, half_z,
    input  ready
  );

  modport sink (
    input  valid, pos_x, pos_y, pos_z, half_x, half_y, half_z,
    output ready
  );
endinterface

interface bsd_out_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] distance;
  logic                         saturated;

  modport source (
    output valid, distance, saturated,
    input  ready
  );

  modport sink (
    input  valid, distance, saturated,
    output ready
  );
endinterface

// File: sv/bsd_front.sv
`timescale 1ns / 1ps

module bsd_front #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic signed [COORD_BITS-1:0] pos_z,
  input  logic        [COORD_BITS-2:0] half_x,
  input  logic        [COORD_BITS-2:0] half_y,
  input  logic        [COORD_BITS-2:0] half_z,
  output logic                         out_valid,
  output logic [2*COORD_BITS-1:0]      sum_sq,
  output logic signed [COORD_BITS:0]   q_max
);

  localparam int CB = COORD_BITS;
  localparam int SW = 2 * COORD_BITS;

  logic        [CB-1:0] pos_a   [bsd_pkg::AXES];
  logic        [CB-2:0] half_a  [bsd_pkg::AXES];
  logic        [CB-1:0] mag     [bsd_pkg::AXES];
  logic signed [CB:0]   q_w     [bsd_pkg::AXES];
  logic        [CB-1:0] pp_w    [bsd_pkg::AXES];

  // stage 1: q and its positive part per axis
  logic        [CB-1:0] pp_r    [bsd_pkg::AXES];
  logic signed [CB:0]   q_r     [bsd_pkg::AXES];
  logic                 v1_r;
  // stage 2: squares and clamped max
  logic        [SW-1:0] sq_r    [bsd_pkg::AXES];
  logic signed [CB:0]   qm2_r;
  logic signed [CB:0]   qm2_nxt;
  logic                 v2_r;
  // stage 3: sum of squares
  logic        [SW-1:0] sum_r;
  logic signed [CB:0]   qm3_r;
  logic                 v3_r;

  always_comb begin
    pos_a[0]  = pos_x;
    pos_a[1]  = pos_y;
    pos_a[2]  = pos_z;
    half_a[0] = half_x;
    half_a[1] = half_y;
    half_a[2] = half_z;
  end

  // most negative coordinate negates to 2^(CB-1), which an unsigned CB-bit value holds
  for (genvar i = 0; i < bsd_pkg::AXES; i++) begin : g_axis
    always_comb begin
      mag[i]  = pos_a[i][CB-1] ? (~pos_a[i] + CB'(1)) : pos_a[i];
      q_w[i]  = signed'({1'b0, mag[i]} - {2'b00, half_a[i]});
      pp_w[i] = (!q_w[i][CB] && (q_w[i] != '0)) ? q_w[i][CB-1:0] : '0;
    end
  end

  always_comb begin
    qm2_nxt = q_r[0];
    if (q_r[1] > qm2_nxt) qm2_nxt = q_r[1];
    if (q_r[2] > qm2_nxt) qm2_nxt = q_r[2];
    if (!qm2_nxt[CB]) qm2_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < bsd_pkg::AXES; i++) begin
        pp_r[i] <= pp_w[i];
        q_r[i]  <= q_w[i];
        sq_r[i] <= pp_r[i] * pp_r[i];
      end
      qm2_r <= qm2_nxt;
      // three squares of at most 2^(2CB-2) each stay below 2^(2CB)
      sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
      qm3_r <= qm2_r;
    end
  end

  assign out_valid = v3_r;
  assign sum_sq    = sum_r;
  assign q_max     = qm3_r;

endmodule

// File: sv/bsd_sqrt_cell.sv
`timescale 1ns / 1ps

module bsd_sqrt_cell #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         i_valid,
  input  logic [2*COORD_BITS-1:0]      i_rad,
  input  logic [COORD_BITS+1:0]        i_rem,
  input  logic [COORD_BITS-1:0]        i_root,
  input  logic signed [COORD_BITS:0]   i_qmax,
  output logic                         o_valid,
  output logic [2*COORD_BITS-1:0]      o_rad,
  output logic [COORD_BITS+1:0]        o_rem,
  output logic [COORD_BITS-1:0]        o_root,
  output logic signed [COORD_BITS:0]   o_qmax
);

  localparam int CB = COORD_BITS;
  localparam int SW = 2 * COORD_BITS;
  localparam int RW = COORD_BITS + 2;
  localparam int TW = RW + bsd_pkg::RAD_STEP;

  logic [TW-1:0]  rem_sh;
  logic [TW-1:0]  trial;
  logic           fit;
  logic [RW-1:0]  rem_nxt;
  logic [CB-1:0]  root_nxt;
  logic [SW-1:0]  rad_nxt;

  logic           valid_r;
  logic [SW-1:0]  rad_r;
  logic [RW-1:0]  rem_r;
  logic [CB-1:0]  root_r;
  logic signed [CB:0] qmax_r;

  // one restoring step: bring down two radicand bits, try 4*root+1
  always_comb begin
    rem_sh   = {i_rem, i_rad[SW-1 -: bsd_pkg::RAD_STEP]};
    trial    = {2'b00, i_root, bsd_pkg::RAD_STEP'(1)};
    fit      = (rem_sh >= trial);
    rem_nxt  = fit ? RW'(rem_sh - trial) : RW'(rem_sh);
    root_nxt = {i_root[CB-2:0], fit};
    rad_nxt  = {i_rad[SW-1-bsd_pkg::RAD_STEP:0], {bsd_pkg::RAD_STEP{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      qmax_r <= i_qmax;
    end
  end

  assign o_valid = valid_r;
  assign o_rad   = rad_r;
  assign o_rem   = rem_r;
  assign o_root  = root_r;
  assign o_qmax  = qmax_r;

endmodule

// File: sv/box_signed_distance_top.sv
`timescale 1ns / 1ps
// signed distance from a point to an axis-aligned box centred at the origin
// in_ch  : one word per voxel - point pos_x/y/z (signed) and half extents
//          half_x/y/z (unsigned), all fixed point with the same fraction bits
// out_ch : one word per input word - distance (signed, negative inside) and
//          saturated, set when the distance was clamped to the most positive value
// words come out in the order they went in, one result per input word
// path: the word enters the first of 3 front stages at the accepting edge,
//       then passes one cell per root bit and the output register, which
//       drives out_ch.valid
// throughput: one word per cycle while not stalled, every stage is a register of the pipeline
// stall: the whole pipeline moves on a common enable; it holds while the
//        output register is full and out_ch.ready is low, and in_ch.ready
//        stays high whenever the output register is empty or being taken;
//        bubbles inside the pipeline are not squeezed out during a stall
// reset: synchronous, active low; clears every stage valid, no words in flight

module box_signed_distance_top #(
  parameter int COORD_BITS = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  bsd_in_if.sink        in_ch,
  bsd_out_if.source     out_ch
);

  localparam int CB = COORD_BITS;
  localparam int SW = 2 * COORD_BITS;
  localparam int RW = COORD_BITS + 2;

  // common pipeline enable
  logic adv;

  // front stages to the root chain
  logic                 f_valid;
  logic [SW-1:0]        f_sum;
  logic signed [CB:0]   f_qmax;

  // root chain taps, entry k feeds cell k
  logic                 c_valid [CB+1];
  logic [SW-1:0]        c_rad   [CB+1];
  logic [RW-1:0]        c_rem   [CB+1];
  logic [CB-1:0]        c_root  [CB+1];
  logic signed [CB:0]   c_qmax  [CB+1];

  // final sum and clamp
  logic signed [CB+1:0] dsum;
  logic                 fits;
  logic [CB-1:0]        dist_nxt;

  // output register
  logic                 out_valid_r;
  logic [CB-1:0]        dist_r;
  logic                 sat_r;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // |p| - half per axis, squares of the positive parts, their sum and max(q) clamped to 0
  bsd_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_ch.valid),
    .pos_x     (in_ch.pos_x),
    .pos_y     (in_ch.pos_y),
    .pos_z     (in_ch.pos_z),
    .half_x    (in_ch.half_x),
    .half_y    (in_ch.half_y),
    .half_z    (in_ch.half_z),
    .out_valid (f_valid),
    .sum_sq    (f_sum),
    .q_max     (f_qmax)
  );

  assign c_valid[0] = f_valid;
  assign c_rad[0]   = f_sum;
  assign c_rem[0]   = '0;
  assign c_root[0]  = '0;
  assign c_qmax[0]  = f_qmax;

  // row of root cells, msb of the root first, each cell one stage
  for (genvar k = 0; k < CB; k++) begin : g_cell
    bsd_sqrt_cell #(
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .i_valid (c_valid[k]),
      .i_rad   (c_rad[k]),
      .i_rem   (c_rem[k]),
      .i_root  (c_root[k]),
      .i_qmax  (c_qmax[k]),
      .o_valid (c_valid[k+1]),
      .o_rad   (c_rad[k+1]),
      .o_rem   (c_rem[k+1]),
      .o_root  (c_root[k+1]),
      .o_qmax  (c_qmax[k+1])
    );
  end

  // floor root plus the clamped max; only the positive side can overflow,
  // but the clamp follows the sign either way
  always_comb begin
    dsum = signed'({2'b00, c_root[CB]}) + signed'({c_qmax[CB][CB], c_qmax[CB]});
    fits = (dsum[CB+1:CB-1] == '0) || (dsum[CB+1:CB-1] == '1);
    if (fits) begin
      dist_nxt = dsum[CB-1:0];
    end else if (dsum[CB+1]) begin
      dist_nxt = {1'b1, {(CB-1){1'b0}}};
    end else begin
      dist_nxt = {1'b0, {(CB-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= c_valid[CB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dist_r <= dist_nxt;
      sat_r  <= !fits;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.distance  = signed'(dist_r);
  assign out_ch.saturated = sat_r;

  // a clamped word always carries the most positive or most negative value
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && sat_r) |->
      (dist_r == {1'b0, {(CB-1){1'b1}}}) || (dist_r == {1'b1, {(CB-1){1'b0}}}))
    else $error("saturated word without a clamped distance");

  // a non-negative root plus a small negative max never clamps downwards
  a_sat_positive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && sat_r) |-> !dist_r[CB-1])
    else $error("distance clamped on the negative side");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !c_valid[CB] && !f_valid)
    else $error("word in flight after reset");

  // a stalled output register keeps the word behind it in place
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(c_valid[CB]) && $stable(c_root[CB])))
    else $error("root chain moved during a stall");

endmodule

// File: tb/sv/box_signed_distance_top_test.sv
`timescale 1ns / 1ps

module box_signed_distance_top_test;

  localparam int CB        = 24;
  localparam int LATENCY   = CB + 4;
  localparam int LONG_HOLD = 300;
  localparam longint POS_MAX  = (64'sd1 <<< (CB - 1)) - 1;
  localparam longint POS_MIN  = -(64'sd1 <<< (CB - 1));
  localparam longint HALF_MAX = (64'sd1 <<< (CB - 1)) - 1;

  // one voxel word and the distance word it gives
  typedef struct packed {
    logic signed [CB-1:0] pos_x;
    logic signed [CB-1:0] pos_y;
    logic signed [CB-1:0] pos_z;
    logic        [CB-2:0] half_x;
    logic        [CB-2:0] half_y;
    logic        [CB-2:0] half_z;
  } voxel_t;

  typedef struct packed {
    logic signed [CB-1:0] distance;
    logic                 saturated;
  } box_dist_t;

  // receiver behaviour while not in the long hold
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

  logic clk;
  logic rst_n;

  bsd_in_if  #(.COORD_BITS(CB)) in_ch ();
  bsd_out_if #(.COORD_BITS(CB)) out_ch ();

  box_signed_distance_top #(.COORD_BITS(CB)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  voxel_t    pending_words [$];   // voxels waiting for the driver
  box_dist_t dist_expected [$];   // predicted distances, oldest first
  int        words_queued  = 0;   // voxels handed to the driver so far
  int        results_seen  = 0;   // distance words taken from the block
  int        errors        = 0;
  logic      in_taken      = 1'b0;
  logic      hold_arm      = 1'b0;

  // sender burst state
  int        burst_left = 0;
  int        gap_left   = 0;
  voxel_t    next_word;

  // receiver state
  int        hold_count = 0;
  int        rx_left    = 0;
  int        rx_tick    = 0;
  rx_mode_t  rx_mode    = RX_OPEN;

  // clock, reset and known values on every input from time zero
  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.pos_x  = '0;
    in_ch.pos_y  = '0;
    in_ch.pos_z  = '0;
    in_ch.half_x = '0;
    in_ch.half_y = '0;
    in_ch.half_z = '0;
    out_ch.ready = 1'b0;
    fork
      forever #5 clk = ~clk;
      begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
      end
    join_none
  end

  // predicted distance: |p| - half per axis, length of the positive parts,
  // plus the largest axis term when the point is inside (never above zero)
  function automatic box_dist_t box_distance(voxel_t v);
    longint    p [bsd_pkg::AXES];
    longint    h [bsd_pkg::AXES];
    longint    q [bsd_pkg::AXES];
    longint    qmax;
    longint    dist_v;
    logic [63:0] sumsq;
    logic [63:0] root;
    logic [63:0] trial;
    int        i;
    int        b;
    box_dist_t r;
    p[0] = v.pos_x;
    p[1] = v.pos_y;
    p[2] = v.pos_z;
    h[0] = longint'(v.half_x);
    h[1] = longint'(v.half_y);
    h[2] = longint'(v.half_z);
    sumsq = '0;
    for (i = 0; i < bsd_pkg::AXES; i++) begin
      // most negative coordinate keeps its full magnitude here
      q[i] = ((p[i] < 0) ? -p[i] : p[i]) - h[i];
      if (q[i] > 0)
        sumsq += q[i] * q[i];
    end
    qmax = q[0];
    for (i = 1; i < bsd_pkg::AXES; i++)
      if (q[i] > qmax) qmax = q[i];
    if (qmax > 0)
      qmax = 0;
    // floor square root, one bit at a time from the top
    root = '0;
    for (b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sumsq)
        root = trial;
    end
    dist_v = longint'(root) + qmax;
    r.saturated = 1'b0;
    if (dist_v > POS_MAX) begin
      dist_v      = POS_MAX;
      r.saturated = 1'b1;
    end else if (dist_v < POS_MIN) begin
      dist_v      = POS_MIN;
      r.saturated = 1'b1;
    end
    r.distance = dist_v[CB-1:0];
    return r;
  endfunction

  function automatic logic signed [CB-1:0] clip_pos(longint x);
    if (x > POS_MAX) return POS_MAX[CB-1:0];
    if (x < POS_MIN) return POS_MIN[CB-1:0];
    return x[CB-1:0];
  endfunction

  function automatic logic [CB-2:0] clip_half(longint x);
    if (x > HALF_MAX) return HALF_MAX[CB-2:0];
    if (x < 0) return '0;
    return x[CB-2:0];
  endfunction

  task automatic queue_voxel(longint px, longint py, longint pz,
                             longint hx, longint hy, longint hz);
    voxel_t v;
    v.pos_x  = clip_pos(px);
    v.pos_y  = clip_pos(py);
    v.pos_z  = clip_pos(pz);
    v.half_x = clip_half(hx);
    v.half_y = clip_half(hy);
    v.half_z = clip_half(hz);
    pending_words.push_back(v);
    words_queued++;
  endtask

  function automatic longint any_pos();
    return longint'($urandom_range(0, 24'hFFFFFF)) + POS_MIN;
  endfunction

  function automatic longint any_half();
    return longint'($urandom_range(0, 23'h7FFFFF));
  endfunction

  // random sign applied to a magnitude
  function automatic longint signed_of(longint m);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  // a point a little inside or outside a face, edge or corner of the box
  function automatic longint near_face(longint h);
    int     j;
    longint off;
    j   = $urandom_range(0, 12);
    off = longint'($urandom_range(0, 2 << j)) - (longint'(1) << j);
    return signed_of(h + off);
  endfunction

  task automatic queue_random_voxel();
    int     kind;
    int     k;
    longint hx;
    longint hy;
    longint hz;
    kind = $urandom_range(0, 9);
    k    = $urandom_range(2, 22);
    hx   = $urandom_range(0, 1 << k);
    hy   = $urandom_range(0, 1 << k);
    hz   = $urandom_range(0, 1 << k);
    case (kind)
      0, 1, 2: begin
        // anything the fields allow
        queue_voxel(any_pos(), any_pos(), any_pos(),
                    any_half(), any_half(), any_half());
      end
      3, 4, 5: begin
        queue_voxel(near_face(hx), near_face(hy), near_face(hz), hx, hy, hz);
      end
      6, 7: begin
        // strictly inside, or on the surface
        queue_voxel(signed_of($urandom_range(0, hx)), signed_of($urandom_range(0, hy)),
                    signed_of($urandom_range(0, hz)), hx, hy, hz);
      end
      8: begin
        // corners of the input range
        queue_voxel($urandom_range(0, 1) ? POS_MIN : POS_MAX,
                    $urandom_range(0, 2) == 0 ? 0 : signed_of(POS_MAX),
                    $urandom_range(0, 1) ? -1 : POS_MIN,
                    $urandom_range(0, 1) ? 0 : HALF_MAX,
                    $urandom_range(0, 2),
                    $urandom_range(0, 1) ? HALF_MAX : $urandom_range(0, 64));
      end
      default: begin
        // tiny values, where the root rounding shows
        queue_voxel(signed_of($urandom_range(0, 64)), signed_of($urandom_range(0, 64)),
                    signed_of($urandom_range(0, 64)), $urandom_range(0, 32),
                    $urandom_range(0, 32), $urandom_range(0, 32));
      end
    endcase
  endtask

  // pause the sender until every queued voxel has its distance back
  task automatic wait_drained();
    while (results_seen != words_queued)
      @(negedge clk);
  endtask

  // driver: a new word goes out at the falling edge once the last one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        next_word     = pending_words.pop_front();
        in_ch.pos_x  <= next_word.pos_x;
        in_ch.pos_y  <= next_word.pos_y;
        in_ch.pos_z  <= next_word.pos_z;
        in_ch.half_x <= next_word.half_x;
        in_ch.half_y <= next_word.half_y;
        in_ch.half_z <= next_word.half_z;
        in_ch.valid  <= 1'b1;
        if (burst_left <= 1) begin
          // now and then a long burst with no gaps at all
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 160)
                                                  : $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: one long hold when armed, otherwise a changing stall pattern
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_arm && hold_count < LONG_HOLD) begin
      hold_count++;
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 96);
      end else begin
        rx_left--;
      end
      rx_tick++;
      case (rx_mode)
        RX_OPEN:   out_ch.ready <= 1'b1;
        RX_COIN:   out_ch.ready <= $urandom_range(0, 1);
        RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:   out_ch.ready <= rx_tick[2];
      endcase
    end
  end

  // monitor: predict on every accepted voxel, check every accepted distance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready)
        dist_expected.push_back(box_distance('{in_ch.pos_x, in_ch.pos_y, in_ch.pos_z,
                                               in_ch.half_x, in_ch.half_y,
                                               in_ch.half_z}));
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (dist_expected.size() == 0) begin
          $error("distance: word with nothing expected, got %0d", out_ch.distance);
          errors++;
        end else begin
          automatic box_dist_t e = dist_expected.pop_front();
          if (out_ch.distance !== e.distance) begin
            $error("distance: expected %0d, got %0d", e.distance, out_ch.distance);
            errors++;
          end
          if (out_ch.saturated !== e.saturated) begin
            $error("saturated: expected %0b, got %0b", e.saturated, out_ch.saturated);
            errors++;
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // directed words
    queue_voxel(0, 0, 0, 0, 0, 0);
    // centre of the biggest box: deepest inside value
    queue_voxel(0, 0, 0, HALF_MAX, HALF_MAX, HALF_MAX);
    // most negative corner of the range, point box: far past the range
    queue_voxel(POS_MIN, POS_MIN, POS_MIN, 0, 0, 0);
    queue_voxel(POS_MAX, POS_MAX, POS_MAX, 0, 0, 0);
    // single axis at full scale, exactly the top of the range
    queue_voxel(POS_MAX, 0, 0, 0, 0, 0);
    // most negative coordinate alone: magnitude one past the top, clamps
    queue_voxel(POS_MIN, 0, 0, 0, 0, 0);
    queue_voxel(0, POS_MIN, 0, 0, 1, 0);
    queue_voxel(0, 0, POS_MIN, 0, 0, 1);
    // on a face, an edge and a corner of the surface
    queue_voxel(4096, 0, 0, 4096, 4096, 4096);
    queue_voxel(-4096, 4096, 0, 4096, 4096, 4096);
    queue_voxel(4096, -4096, -4096, 4096, 4096, 4096);
    // inside off centre
    queue_voxel(-1000, 2000, -3000, 8192, 8192, 8192);
    // outside past an edge and past a corner
    queue_voxel(5000, -5000, 0, 4096, 4096, 4096);
    queue_voxel(-5000, 6000, -7000, 4096, 4096, 4096);
    // root rounding down on tiny lengths
    queue_voxel(1, 1, 0, 0, 0, 0);
    queue_voxel(1, -1, 1, 0, 0, 0);
    queue_voxel(2, 2, 1, 0, 0, 0);
    // full-scale point on the full-scale box, both signs
    queue_voxel(POS_MAX, POS_MAX, POS_MAX, HALF_MAX, HALF_MAX, HALF_MAX);
    queue_voxel(POS_MIN, POS_MIN, POS_MIN, HALF_MAX, HALF_MAX, HALF_MAX);
    // mixed: one axis outside, two far inside
    queue_voxel(POS_MIN, 0, -1, 0, HALF_MAX, HALF_MAX);
    // alternating bit patterns on most fields
    queue_voxel(24'sh555555, -24'sh2AAAAB, 24'sh2AAAAA, 23'h2AAAAA, 23'h555555, 23'h7FFFFF);
    queue_voxel(-24'sh2AAAAA, 24'sh555555, -24'sh555556, 23'h555555, 23'h2AAAAA, 0);
    queue_voxel(-1, -1, -1, 0, 0, 0);
    wait_drained();

    // long receiver hold while the sender keeps offering
    @(posedge clk);
    hold_arm <= 1'b1;
    repeat (150) queue_random_voxel();
    wait_drained();

    // random chunks, some followed by a full drain
    for (int chunk = 0; chunk < 9; chunk++) begin
      repeat (200) queue_random_voxel();
      if (chunk % 3 == 1)
        wait_drained();
    end
    wait_drained();

    // let anything stray come out of the pipeline
    repeat (LATENCY + 8) @(posedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // watchdog
  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

endmodule
